[src/mvcc_pkg.sv]
package mvcc_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 16;
  localparam int DISP_W     = COORD_W + 1;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = DISP_W + ADDR_W;
  localparam int EPS_W      = 16;
  localparam int EPS_SHIFT  = 8;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd51;
  localparam int OUT_CNT_W  = 11;

  // n * d, with n taken as a signed value one bit wider than the count
  localparam int PROD_W = DISP_W + CNT_W + 1;
  localparam int DIFF_W = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
  localparam int LHS_W  = DIFF_W + EPS_SHIFT;
  localparam int RHS_W  = EPS_W + SUM_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one classified pair on its way from the front to the back
  typedef struct packed {
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
    logic                     last;
    logic                     drop;
  } item_t;

  typedef struct packed {
    logic                 parallel;
    logic [OUT_CNT_W-1:0] inlier_count;
    logic [OUT_CNT_W-1:0] outlier_count;
    logic                 overflow;
  } res_t;

endpackage

[src/mvcc_front.sv]
module mvcc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_obj_x,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_obj_y,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_scene_x,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_scene_y,
  input  logic                          in_last,
  output logic                          q_push,
  output mvcc_pkg::item_t               q_item,
  input  logic                          q_full
);
  import mvcc_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             drop;

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full;
  // pairs past the store depth are only flagged
  assign drop    = (cnt_r == CNT_W'(MAX_POINTS));

  assign q_item.dx   = $signed({1'b0, in_scene_x}) - $signed({1'b0, in_obj_x});
  assign q_item.dy   = $signed({1'b0, in_scene_y}) - $signed({1'b0, in_obj_y});
  assign q_item.last = in_last;
  assign q_item.drop = drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      if (in_last) begin
        cnt_r <= '0;
      end else if (!drop) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

[src/mvcc_queue.sv]
module mvcc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mvcc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output mvcc_pkg::item_t pop_item,
  output logic            empty
);
  import mvcc_pkg::*;

  item_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_item = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[src/mvcc_back.sv]
module mvcc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mvcc_pkg::EPS_W-1:0]  cfg_wr_data,
  input  logic                        q_empty,
  input  mvcc_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output mvcc_pkg::res_t              out_res
);
  import mvcc_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  typedef struct packed {
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
  } disp_t;

  disp_t                    mem_r [MAX_POINTS];
  disp_t                    rd_data_r;

  logic [1:0]               st_r;
  logic [EPS_W-1:0]         eps_r;
  logic signed [SUM_W-1:0]  sum_x_r;
  logic signed [SUM_W-1:0]  sum_y_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     ovf_r;
  logic [RHS_W-1:0]         rhs_x_r;
  logic [RHS_W-1:0]         rhs_y_r;
  logic [CNT_W-1:0]         rd_idx_r;
  logic                     va_r;
  logic                     vb_r;
  logic                     vc_r;
  logic signed [PROD_W-1:0] prod_x_r;
  logic signed [PROD_W-1:0] prod_y_r;
  logic                     off_r;
  logic [CNT_W-1:0]         inl_r;
  logic [CNT_W-1:0]         outl_r;
  logic                     out_valid_r;
  res_t                     out_res_r;

  logic                     wr_en;
  logic                     rd_en;
  logic                     out_free;
  res_t                     res_nxt;
  logic [SUM_W-1:0]         abs_sx;
  logic [SUM_W-1:0]         abs_sy;
  logic                     off_nxt;

  function automatic logic off_axis(logic signed [PROD_W-1:0] prod,
                                    logic signed [SUM_W-1:0]  sum,
                                    logic [RHS_W-1:0]         rhs);
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [CMP_W-1:0]         lhs;
    diff = DIFF_W'(prod) - DIFF_W'(sum);
    mag  = (diff < 0) ? DIFF_W'(-diff) : DIFF_W'(diff);
    lhs  = CMP_W'({mag, {EPS_SHIFT{1'b0}}});
    return lhs > CMP_W'(rhs);
  endfunction

  assign q_pop     = (st_r == ST_LOAD) & ~q_empty;
  assign wr_en     = q_pop & ~q_item.drop;
  assign rd_en     = (st_r == ST_EVAL) && (rd_idx_r < cnt_r);
  assign out_free  = ~out_valid_r | out_pop;
  assign out_empty = ~out_valid_r;
  assign out_res   = out_res_r;

  assign abs_sx  = (sum_x_r < 0) ? SUM_W'(-sum_x_r) : SUM_W'(sum_x_r);
  assign abs_sy  = (sum_y_r < 0) ? SUM_W'(-sum_y_r) : SUM_W'(sum_y_r);
  assign off_nxt = off_axis(prod_x_r, sum_x_r, rhs_x_r) |
                   off_axis(prod_y_r, sum_y_r, rhs_y_r);

  always_comb begin
    if (ovf_r) begin
      res_nxt.parallel      = 1'b0;
      res_nxt.inlier_count  = '0;
      res_nxt.outlier_count = '0;
      res_nxt.overflow      = 1'b1;
    end else begin
      res_nxt.parallel      = (inl_r >= outl_r);
      res_nxt.inlier_count  = OUT_CNT_W'(inl_r);
      res_nxt.outlier_count = OUT_CNT_W'(outl_r);
      res_nxt.overflow      = 1'b0;
    end
  end

  // displacement store: one write port while loading, one read port while evaluating
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[cnt_r[ADDR_W-1:0]] <= '{dx: q_item.dx, dy: q_item.dy};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx_r[ADDR_W-1:0]];
    end
  end

  // evaluation datapath
  always_ff @(posedge clk) begin
    prod_x_r <= PROD_W'($signed({1'b0, cnt_r})) * PROD_W'(rd_data_r.dx);
    prod_y_r <= PROD_W'($signed({1'b0, cnt_r})) * PROD_W'(rd_data_r.dy);
    off_r    <= off_nxt;
    if (st_r == ST_PREP) begin
      rhs_x_r <= RHS_W'(eps_r) * RHS_W'(abs_sx);
      rhs_y_r <= RHS_W'(eps_r) * RHS_W'(abs_sy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      eps_r       <= EPS_RESET;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_idx_r    <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      inl_r       <= '0;
      outl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
      if ((st_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      va_r <= rd_en;
      vb_r <= va_r;
      vc_r <= vb_r;
      if (vc_r) begin
        if (off_r) begin
          outl_r <= outl_r + 1'b1;
        end else begin
          inl_r <= inl_r + 1'b1;
        end
      end

      unique case (st_r)
        ST_LOAD: begin
          if (q_pop) begin
            if (q_item.drop) begin
              ovf_r <= 1'b1;
            end else begin
              sum_x_r <= sum_x_r + SUM_W'(q_item.dx);
              sum_y_r <= sum_y_r + SUM_W'(q_item.dy);
              cnt_r   <= cnt_r + 1'b1;
            end
            if (q_item.last) begin
              st_r <= (q_item.drop || ovf_r) ? ST_FIN : ST_PREP;
            end
          end
        end
        ST_PREP: begin
          inl_r    <= '0;
          outl_r   <= '0;
          rd_idx_r <= '0;
          st_r     <= ST_EVAL;
        end
        ST_EVAL: begin
          if (rd_en) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end else if (!va_r && !vb_r && !vc_r) begin
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_res_r   <= res_nxt;
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            inl_r       <= '0;
            outl_r      <= '0;
            st_r        <= ST_LOAD;
          end
        end
        default: begin
          st_r <= ST_LOAD;
        end
      endcase
    end
  end

  a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EVAL) |-> (rd_idx_r <= cnt_r))
    else $error("read index ran past the stored pair count");

  a_counts_cover_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FIN) && !ovf_r) |->
      (({1'b0, inl_r} + {1'b0, outl_r}) == {1'b0, cnt_r}))
    else $error("inlier and outlier counts do not add up to the run length");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r < CNT_W'(MAX_POINTS)))
    else $error("store write beyond the displacement memory");

  a_pipe_empty_outside_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_EVAL) |-> (!va_r && !vb_r && !vc_r))
    else $error("evaluation pipeline busy outside the evaluation pass");

endmodule

[src/match_vector_consensus_check.sv]
// Channel   Direction  Handshake            Payload
// in_       input      in_push / in_full    in_obj_x, in_obj_y, in_scene_x, in_scene_y, in_last
// out_      output     out_empty / out_pop  out_parallel, out_inlier_count,
//                                           out_outlier_count, out_overflow
// cfg_      input      cfg_wr_en            cfg_wr_data (epsilon_q8)
//
// While the back end is loading, one pair a cycle moves from a four-entry queue into the
// displacement memory. After the last pair leaves the queue, the back end scales the
// tolerance, then reads the memory once per pair through a four-stage compare pipe; it
// takes no new pair until the run's result is handed to the output register.
// Synchronous active-low reset; epsilon returns to 51, the store is not cleared.
// A result waiting on out_pop stalls the next run's end, so in_full rises once the queue fills.
module match_vector_consensus_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mvcc_pkg::EPS_W-1:0]    cfg_wr_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_obj_x,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_obj_y,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_scene_x,
  input  logic [mvcc_pkg::COORD_W-1:0]  in_scene_y,
  input  logic                          in_last,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_parallel,
  output logic [mvcc_pkg::OUT_CNT_W-1:0] out_inlier_count,
  output logic [mvcc_pkg::OUT_CNT_W-1:0] out_outlier_count,
  output logic                          out_overflow
);
  import mvcc_pkg::*;

  logic  fq_push;
  item_t fq_item;
  logic  fq_full;
  logic  bq_pop;
  item_t bq_item;
  logic  bq_empty;
  res_t  res;

  mvcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_obj_x   (in_obj_x),
    .in_obj_y   (in_obj_y),
    .in_scene_x (in_scene_x),
    .in_scene_y (in_scene_y),
    .in_last    (in_last),
    .q_push     (fq_push),
    .q_item     (fq_item),
    .q_full     (fq_full)
  );

  mvcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (bq_pop),
    .pop_item  (bq_item),
    .empty     (bq_empty)
  );

  mvcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (bq_empty),
    .q_item      (bq_item),
    .q_pop       (bq_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_res     (res)
  );

  assign out_parallel      = res.parallel;
  assign out_inlier_count  = res.inlier_count;
  assign out_outlier_count = res.outlier_count;
  assign out_overflow      = res.overflow;

endmodule

[bench/match_vector_consensus_check_test.sv]
`timescale 1ns / 100ps

module match_vector_consensus_check_test;
  import mvcc_pkg::*;

  class consensus_board;
    logic [EPS_W-1:0] epsilon = EPS_RESET;
    int               disp_x [MAX_POINTS];
    int               disp_y [MAX_POINTS];
    longint           sum_x;
    longint           sum_y;
    int               pairs;
    bit               spilled;
    res_t             verdicts_due [$];
    int               errors;

    function int pending();
      return verdicts_due.size();
    endfunction

    // division-free test: 256*|n*d - s| > eps*|s|
    function bit off_tolerance(longint n, longint d, longint s);
      longint dev;
      longint span;
      dev = n * d - s;
      if (dev < 0) dev = -dev;
      span = (s < 0) ? -s : s;
      return dev * (1 << EPS_SHIFT) > longint'(epsilon) * span;
    endfunction

    function void take_pair(logic [15:0] ox, logic [15:0] oy, logic [15:0] sx,
                            logic [15:0] sy, logic last);
      res_t verdict;
      int   inl;
      int   outl;
      if (pairs < MAX_POINTS) begin
        disp_x[pairs] = int'(sx) - int'(ox);
        disp_y[pairs] = int'(sy) - int'(oy);
        sum_x += disp_x[pairs];
        sum_y += disp_y[pairs];
        pairs++;
      end else begin
        spilled = 1'b1;
      end
      if (!last) return;
      verdict = '0;
      if (spilled) begin
        verdict.overflow = 1'b1;
      end else begin
        inl  = 0;
        outl = 0;
        for (int i = 0; i < pairs; i++) begin
          if (off_tolerance(pairs, disp_x[i], sum_x) ||
              off_tolerance(pairs, disp_y[i], sum_y))
            outl++;
          else
            inl++;
        end
        verdict.parallel      = (inl >= outl);
        verdict.inlier_count  = OUT_CNT_W'(inl);
        verdict.outlier_count = OUT_CNT_W'(outl);
      end
      verdicts_due = {verdicts_due, verdict};
      // start a new run
      sum_x   = 0;
      sum_y   = 0;
      pairs   = 0;
      spilled = 1'b0;
    endfunction

    function void check_result(res_t seen);
      res_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no run pending: par=%0b in=%0d out=%0d ovf=%0b",
                   $time, seen.parallel, seen.inlier_count, seen.outlier_count,
                   seen.overflow);
        return;
      end
      want = verdicts_due.pop_front();
      if (seen.parallel !== want.parallel || seen.inlier_count !== want.inlier_count ||
          seen.outlier_count !== want.outlier_count || seen.overflow !== want.overflow) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch: expected par=%0b in=%0d out=%0d ovf=%0b, ",
                    "got par=%0b in=%0d out=%0d ovf=%0b"},
                   $time, want.parallel, want.inlier_count, want.outlier_count,
                   want.overflow, seen.parallel, seen.inlier_count,
                   seen.outlier_count, seen.overflow);
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD   = 400;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [EPS_W-1:0] cfg_wr_data = '0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [15:0]      in_obj_x = '0;
  logic [15:0]      in_obj_y = '0;
  logic [15:0]      in_scene_x = '0;
  logic [15:0]      in_scene_y = '0;
  logic             in_last = 1'b0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic             out_parallel;
  logic [OUT_CNT_W-1:0] out_inlier_count;
  logic [OUT_CNT_W-1:0] out_outlier_count;
  logic             out_overflow;

  consensus_board board = new;
  int             items_sent;
  int             quiet_cycles;
  bit             send_burst;
  bit             hold_request;

  match_vector_consensus_check u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_obj_x         (in_obj_x),
    .in_obj_y         (in_obj_y),
    .in_scene_x       (in_scene_x),
    .in_scene_y       (in_scene_y),
    .in_last          (in_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_parallel     (out_parallel),
    .out_inlier_count (out_inlier_count),
    .out_outlier_count(out_outlier_count),
    .out_overflow     (out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap(bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_base();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 0;
    if (roll < 80) return int'($urandom_range(0, 6000)) - 3000;
    return int'($urandom_range(0, 131070)) - 65535;
  endfunction

  // choose a point pair whose displacement is d, clamped to the coordinate range
  function automatic void place(int d, output logic [15:0] o, output logic [15:0] s);
    if (d > 65535) d = 65535;
    if (d < -65535) d = -65535;
    if (d >= 0) o = 16'($urandom_range(0, 65535 - d));
    else o = 16'($urandom_range(-d, 65535));
    s = 16'(int'(o) + d);
  endfunction

  task automatic send_pair(input logic [15:0] ox, input logic [15:0] oy,
                           input logic [15:0] sx, input logic [15:0] sy, input logic last);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push    <= 1'b1;
    in_obj_x   <= ox;
    in_obj_y   <= oy;
    in_scene_x <= sx;
    in_scene_y <= sy;
    in_last    <= last;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  // a run around one common displacement, with random jitter and a random share of unrelated pairs
  task automatic send_run(input int len);
    int          base_x;
    int          base_y;
    int          spread;
    int          noise;
    int          roll;
    logic [15:0] ox, oy, sx, sy;
    base_x = pick_base();
    base_y = pick_base();
    case ($urandom_range(0, 2))
      0: begin
        spread = 0;
      end
      1: begin
        spread = $urandom_range(1, 8);
      end
      default: begin
        spread = $urandom_range(10, 300);
      end
    endcase
    roll = $urandom_range(0, 9);
    noise = (roll < 7) ? 0 : (roll < 9) ? int'($urandom_range(10, 30)) : 100;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < noise) begin
        ox = 16'($urandom);
        oy = 16'($urandom);
        sx = 16'($urandom);
        sy = 16'($urandom);
      end else begin
        place(base_x + int'($urandom_range(0, 2 * spread)) - spread, ox, sx);
        place(base_y + int'($urandom_range(0, 2 * spread)) - spread, oy, sy);
      end
      send_pair(ox, oy, sx, sy, k == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.epsilon = value;
  endtask

  always @(posedge clk) begin : watch
    res_t seen;
    if (in_push && !in_full)
      board.take_pair(in_obj_x, in_obj_y, in_scene_x, in_scene_y, in_last);
    if (out_pop && !out_empty) begin
      seen.parallel      = out_parallel;
      seen.inlier_count  = out_inlier_count;
      seen.outlier_count = out_outlier_count;
      seen.overflow      = out_overflow;
      board.check_result(seen);
    end
    if ((in_push && !in_full) || (out_pop && !out_empty))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("match_vector_consensus_check_test: FAIL");
      $finish;
    end
  end

  initial begin : pop_side
    int stall;
    bit burst;
    stall = 0;
    burst = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end
      if ($urandom_range(0, 299) == 0) burst = !burst;
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        stall = pick_gap(burst);
      end
    end
  end

  initial begin : stimulus
    logic [EPS_W-1:0] eps_table [7];
    int               stop_at;
    int               roll;
    bit               paused;
    eps_table = '{16'd0, 16'hFFFF, 16'd256, 16'd51, 16'd0, 16'd1, 16'd12800};
    eps_table[4] = EPS_W'($urandom);
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // single pair at zero
    send_pair(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    // single pair, widest displacement both ways
    send_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
    // zero average on x with nonzero displacements
    send_pair(16'd100, 16'd100, 16'd105, 16'd100, 1'b0);
    send_pair(16'd100, 16'd100, 16'd95, 16'd100, 1'b1);
    // no motion at the top of the range
    repeat (2) send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // common displacement from different points
    send_pair(16'd1000, 16'd0, 16'd700, 16'd700, 1'b0);
    send_pair(16'd5000, 16'd3000, 16'd4700, 16'd3700, 1'b0);
    send_pair(16'd300, 16'd64000, 16'd0, 16'd64700, 1'b0);
    send_pair(16'd40000, 16'd20, 16'd39700, 16'd720, 1'b1);
    // one pair off on y only
    send_pair(16'd10, 16'd10, 16'd60, 16'd20, 1'b0);
    send_pair(16'd20, 16'd20, 16'd70, 16'd30, 1'b0);
    send_pair(16'd30, 16'd30, 16'd80, 16'd430, 1'b1);
    // corners crossing each other
    send_pair(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0);
    send_pair(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    send_pair(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      repeat (20) @(posedge clk);
      write_epsilon(eps_table[p]);
      stop_at = items_sent + 40;
      if (p == 1) begin
        // hold the result side and keep pushing through any stall of the input
        send_burst   = 1'b1;
        hold_request = 1'b1;
      end
      while (items_sent < stop_at) begin
        if (p == 2 && !paused && items_sent > stop_at - 20) begin
          wait_drained();
          paused = 1'b1;
        end
        if (p != 1 && $urandom_range(0, 9) == 0) send_burst = !send_burst;
        roll = $urandom_range(0, 99);
        if (roll < 70) send_run($urandom_range(1, 6));
        else if (roll < 95) send_run($urandom_range(7, 24));
        else send_run($urandom_range(25, 40));
      end
      send_burst = 1'b0;
    end

    // a run one pair past the store depth, then a short run after the overflow
    wait_drained();
    repeat (20) @(posedge clk);
    write_epsilon(16'd51);
    send_run(MAX_POINTS + 1);
    send_run(3);

    wait_drained();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("match_vector_consensus_check_test: PASS");
    else
      $display("match_vector_consensus_check_test: FAIL");
    $finish;
  end

endmodule
